### rtl/first_gap_binary_search_macros.svh
// ----------------------------------------------------------------------------
// first_gap_binary_search_macros.svh
// Assertion macros shared by the first-gap search RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_GAP_BINARY_SEARCH_MACROS_SVH
`define FIRST_GAP_BINARY_SEARCH_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define FGBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fgbs assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define FGBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fgbs assertion failed");
`else
`define FGBS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FGBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/fgbs_pkg.sv
// ----------------------------------------------------------------------------
// fgbs_pkg
// Shared constants and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package fgbs_pkg;

    localparam int unsigned FGBS_DEPTH       = 1024;
    localparam int unsigned FGBS_VALUE_WIDTH = 32;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;    // accepted input beat: store element
        logic start;   // beat closed the set: set up search bounds
        logic step;    // apply one halving decision
        logic finish;  // capture result, clear set
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic last_step;  // bounds span at most one entry
    } t_status;

endpackage

`default_nettype wire

### rtl/fgbs_if.sv
// ----------------------------------------------------------------------------
// fgbs_if
// Valid/ready channel interfaces for input elements and search results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fgbs_in_if #(
    parameter int unsigned VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface fgbs_out_if #(
    parameter int unsigned VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] found;
    logic                          overflowed;

    modport source (output valid, output found, output overflowed, input ready);
    modport sink   (input valid, input found, input overflowed, output ready);
endinterface

`default_nettype wire

### rtl/fgbs_datapath.sv
// ----------------------------------------------------------------------------
// fgbs_datapath
// Element store, search bounds, consecutiveness compares and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fgbs_datapath #(
    parameter int unsigned DEPTH       = 1024,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire fgbs_pkg::t_cmd          i_cmd,
    input  wire signed [VALUE_WIDTH-1:0] i_value,
    output fgbs_pkg::t_status            o_status,
    output logic signed [VALUE_WIDTH-1:0] o_found,
    output logic                         o_overflowed
);
    import fgbs_pkg::*;

    localparam int unsigned IDX_W  = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned DIFF_W = ((VALUE_WIDTH >= IDX_W) ? VALUE_WIDTH : IDX_W) + 1;

    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_a;     // store[mid-1]
    logic [VALUE_WIDTH-1:0] r_rd_b;     // store[mid], or store[hi] on the last step
    logic [VALUE_WIDTH-1:0] r_lo_val;   // store[lo], kept in step with r_lo
    logic [VALUE_WIDTH-1:0] r_found;
    logic                   r_found_ovf;

    logic [CNT_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_lo, n_lo;
    logic [IDX_W-1:0] r_hi, n_hi;
    logic             r_ovf, n_ovf;

    logic             full;
    logic [IDX_W-1:0] span, half, mid, addr_a, addr_b;
    logic [DIFF_W-1:0] d_pair, d_run, d_tail;
    logic             pair_ok, run_ok, tail_ok;
    logic [VALUE_WIDTH-1:0] result;

    assign full   = (r_fill == CNT_W'(DEPTH));
    assign span   = r_hi - r_lo;
    assign half   = span >> 1;
    assign mid    = r_lo + half;
    assign addr_a = mid - IDX_W'(1);
    assign addr_b = (span == IDX_W'(1)) ? r_hi : mid;

    // Exact signed differences, one bit wider than either operand.
    assign d_pair = {{(DIFF_W-VALUE_WIDTH){r_rd_b[VALUE_WIDTH-1]}}, r_rd_b}
                  - {{(DIFF_W-VALUE_WIDTH){r_rd_a[VALUE_WIDTH-1]}}, r_rd_a};
    assign d_run  = {{(DIFF_W-VALUE_WIDTH){r_rd_b[VALUE_WIDTH-1]}}, r_rd_b}
                  - {{(DIFF_W-VALUE_WIDTH){r_lo_val[VALUE_WIDTH-1]}}, r_lo_val};
    assign d_tail = d_run;

    assign pair_ok = (d_pair == DIFF_W'(1));
    assign run_ok  = (d_run == {{(DIFF_W-IDX_W){1'b0}}, half});
    assign tail_ok = (d_tail == DIFF_W'(1));

    always_comb begin
        if (span == '0) begin
            result = r_lo_val;
        end else begin
            result = tail_ok ? r_rd_b : r_lo_val;
        end
    end

    assign o_status.last_step = (span <= IDX_W'(1));

    // Store and registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            r_mem[r_fill[IDX_W-1:0]] <= i_value;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    always_comb begin
        n_fill = r_fill;
        n_lo   = r_lo;
        n_hi   = r_hi;
        n_ovf  = r_ovf;
        if (i_cmd.load) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_fill = r_fill + CNT_W'(1);
            end
        end
        if (i_cmd.start) begin
            n_lo = '0;
            n_hi = full ? IDX_W'(DEPTH - 1) : r_fill[IDX_W-1:0];
        end
        if (i_cmd.step) begin
            if (pair_ok && run_ok) begin
                n_lo = mid;
            end else begin
                n_hi = mid;
            end
        end
        if (i_cmd.finish) begin
            n_fill = '0;
            n_ovf  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_lo   <= '0;
            r_hi   <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_fill == '0)) begin
            r_lo_val <= i_value;
        end else if (i_cmd.step && pair_ok && run_ok) begin
            r_lo_val <= r_rd_b;
        end
        if (i_cmd.finish) begin
            r_found     <= result;
            r_found_ovf <= r_ovf;
        end
    end

    assign o_found      = r_found;
    assign o_overflowed = r_found_ovf;

endmodule

`default_nettype wire

### rtl/fgbs_ctrl.sv
// ----------------------------------------------------------------------------
// fgbs_ctrl
// Load/search sequencer and result-valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module fgbs_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_last,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    input  wire fgbs_pkg::t_status i_status,
    output fgbs_pkg::t_cmd     o_cmd
);
    import fgbs_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_ISSUE = 3'b010,   // read addresses settle, data lands next cycle
        S_EVAL  = 3'b100    // decide on read data
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!i_status.last_step) begin
                    o_cmd.step = 1'b1;
                    n_state    = S_ISSUE;
                end else if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### rtl/first_gap_binary_search.sv
// ----------------------------------------------------------------------------
// first_gap_binary_search
// Collects an ascending set and binary-searches the value just before its gap.
// ----------------------------------------------------------------------------
//
//  port    dir   beat contents           note
//  i_in    sink  value, last             one element per beat, last closes set
//  o_out   src   found, overflowed       one beat per closed set
//
//  Loading takes one beat per cycle; elements past DEPTH are dropped and flagged.
//  After the closing beat the search runs with input held off: each halving is
//  a registered read of the store's two read ports, then the decision.
//  The result sits in an output register; the next set loads while it waits.
//  A search that ends with the previous result still untaken waits for it.
//  Reset (i_rst_n, synchronous, active low) clears counts, bounds and valids;
//  the store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_gap_binary_search_macros.svh"

module first_gap_binary_search #(
    parameter int unsigned DEPTH       = fgbs_pkg::FGBS_DEPTH,
    parameter int unsigned VALUE_WIDTH = fgbs_pkg::FGBS_VALUE_WIDTH
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    fgbs_in_if.sink   i_in,
    fgbs_out_if.source o_out
);
    import fgbs_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    out_valid;

    // Sequencer: owns input ready, result valid and the search loop.
    fgbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last),
        .o_in_ready  (i_in.ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Store, bounds, compares and result register.
    fgbs_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_in.value),
        .o_status     (status),
        .o_found      (o_out.found),
        .o_overflowed (o_out.overflowed)
    );

    assign o_out.valid = out_valid;

    // Input is held off for the whole search.
    `FGBS_ASSERT_NEXT(a_start_blocks_input, i_clk, i_rst_n, cmd.start, !i_in.ready)
    // A finishing search lands its result in the output register.
    `FGBS_ASSERT_NEXT(a_finish_gives_valid, i_clk, i_rst_n, cmd.finish, o_out.valid)
    // A pending result is never overwritten.
    `FGBS_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, cmd.finish, !out_valid || o_out.ready)
    // Halving only while the bounds still span two or more entries.
    `FGBS_ASSERT_SAME(a_step_span, i_clk, i_rst_n, cmd.step, !status.last_step)

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives element sets into first_gap_binary_search and checks every result
// beat against a local prediction of the search. It covers directed edge
// sets, an overflowing store, long output backpressure, and random
// sets under four idling profiles.
// ----------------------------------------------------------------------------

module testbench;

    import fgbs_pkg::*;

    localparam int unsigned DEPTH = FGBS_DEPTH;
    localparam int unsigned VW    = FGBS_VALUE_WIDTH;

    // A gap-free stretch can still be long: a 1024-entry search plus the forced
    // hold-off on the result port. A quiet stretch reaching QUIET_LIMIT means the block is stuck.
    localparam int QUIET_LIMIT   = 3000;
    // Give the tail after the last search some margin.
    localparam int TAIL_CYCLES   = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_BEATS  = 770;

    typedef logic signed [VW-1:0] elem_t;

    typedef struct {
        elem_t found;
        bit    overflowed;
    } gap_result_t;

    localparam elem_t VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam elem_t VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam longint VMIN_L = -(longint'(1) << (VW - 1));
    localparam longint VMAX_L = (longint'(1) << (VW - 1)) - 1;
    localparam longint VSPAN  = longint'(1) << VW;   // count of distinct values

    logic i_clk = 1'b0;
    logic i_rst_n;

    fgbs_in_if  #(.VALUE_WIDTH(VW)) in_if ();
    fgbs_out_if #(.VALUE_WIDTH(VW)) out_if ();

    first_gap_binary_search #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared state
    // ------------------------------------------------------------------------
    int send_idle_pct = 0;    // chance per cycle that the sender sits idle
    int stall_pct     = 0;    // chance per cycle that the receiver deasserts ready
    int hold_left     = 0;    // pending forced receiver hold-off, in cycles
    int beats_sent    = 0;
    int miscompares   = 0;
    int quiet_cycles  = 0;

    gap_result_t gap_results[$];   // predicted result beats, oldest first

    // Local copy of the block's set storage.
    elem_t       set_store[DEPTH];
    int unsigned set_fill = 0;
    bit          set_dropped = 1'b0;

    // ------------------------------------------------------------------------
    // Search prediction
    // ------------------------------------------------------------------------

    // b follows a by exactly k, with no wrap at the field width
    function automatic bit steps_by(elem_t a, elem_t b, longint k);
        longint la;
        longint lb;
        la = a;
        lb = b;
        return (lb - la) == k;
    endfunction

    // Binary search for the last value of the leading consecutive run.
    // Bounds narrow the same way the block does it, so unsorted or
    // multi-gap sets land on the same element.
    function automatic elem_t leading_run_end(int unsigned n);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (!steps_by(set_store[mid-1], set_store[mid], 1))
                hi = mid;
            else if (steps_by(set_store[lo], set_store[mid], longint'(mid - lo)))
                lo = mid;
            else
                hi = mid;
        end
        if (hi == lo)
            return set_store[lo];
        return steps_by(set_store[lo], set_store[hi], 1) ? set_store[hi] : set_store[lo];
    endfunction

    // Accepted beat: store it (or drop it once full); a closing beat queues
    // the predicted result and opens a fresh set.
    function automatic void absorb_element(elem_t v, bit close);
        gap_result_t r;
        if (set_fill < DEPTH) begin
            set_store[set_fill] = v;
            set_fill++;
        end else begin
            set_dropped = 1'b1;
        end
        if (close) begin
            r.found      = leading_run_end(set_fill);
            r.overflowed = set_dropped;
            gap_results.push_back(r);
            set_fill    = 0;
            set_dropped = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // valid stays high after a beat until the next falling edge decides,
    // so it is never dropped and raised in the same step.
    task automatic drive_element(input elem_t v, input bit close);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_if.valid <= 1'b1;
        in_if.value <= v;
        in_if.last  <= close;
        do @(posedge i_clk); while (!in_if.ready);
        absorb_element(v, close);
        beats_sent++;
    endtask

    task automatic send_values(input elem_t vals[$]);
        foreach (vals[i])
            drive_element(vals[i], i == vals.size() - 1);
    endtask

    // Sender pause: nothing offered until every predicted beat came back.
    task automatic wait_for_results();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (gap_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // Consecutive run of n values from base, one jump before index gap_at
    // (gap_at == 0: no gap). Caller keeps the whole span in range.
    task automatic send_run(input int n, input longint base, input int gap_at,
                            input longint jump);
        elem_t  q[$];
        longint v;
        v = base;
        for (int i = 0; i < n; i++) begin
            if (i > 0)
                v += (i == gap_at) ? jump : 1;
            q.push_back(elem_t'(v));
        end
        send_values(q);
    endtask

    // Well-formed set with random placement, gap size and base.
    task automatic send_shaped_set(input int n);
        int                  gap_at;
        int unsigned         pick;
        longint              jump;
        longint              span;
        longint unsigned     room;
        longint unsigned     draw;
        longint              base;
        gap_at = (n > 1 && $urandom_range(3) != 0) ? $urandom_range(n - 1, 1) : 0;
        pick = $urandom_range(99);
        if (pick < 25)
            jump = 2;
        else if (pick < 65)
            jump = $urandom_range(100, 3);
        else
            jump = longint'($urandom) + 2;
        span = (n - 1) + ((gap_at != 0) ? jump - 1 : 0);
        if (span > VSPAN - 1) begin
            jump = VSPAN - n + 1;
            span = VSPAN - 1;
        end
        room = VSPAN - span;
        draw = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       base = VMIN_L;
            1:       base = VMAX_L - span;
            default: base = VMIN_L + longint'(draw % room);
        endcase
        send_run(n, base, gap_at, jump);
    endtask

    // Noise: fully random values, or small steps with repeats and many gaps.
    task automatic send_noise_set(input int n);
        elem_t q[$];
        elem_t v;
        bit    wild;
        wild = $urandom_range(1);
        v    = $urandom;
        for (int i = 0; i < n; i++) begin
            if (wild) begin
                v = $urandom;
            end else if (i > 0) begin
                case ($urandom_range(5))
                    0:       v = v;
                    4:       v = v + 2;
                    5:       v = v + elem_t'($urandom_range(9, 3));
                    default: v = v + 1;
                endcase
            end
            q.push_back(v);
        end
        send_values(q);
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic note_mismatch(input string what, input gap_result_t want);
        miscompares++;
        if (miscompares <= 10)
            $display("%s: expected found=%0d overflowed=%0b, got found=%0d overflowed=%0b",
                     what, want.found, want.overflowed, out_if.found, out_if.overflowed);
    endtask

    always @(posedge i_clk) begin : result_check
        gap_result_t want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (gap_results.size() == 0) begin
                want.found      = '0;
                want.overflowed = 1'b0;
                note_mismatch("unexpected result beat", want);
            end else begin
                want = gap_results.pop_front();
                if (out_if.found !== want.found)
                    note_mismatch("found differs", want);
                else if (out_if.overflowed !== want.overflowed)
                    note_mismatch("overflowed differs", want);
            end
        end
    end

    // Watchdog: any beat on either port resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("first_gap_binary_search: mismatch");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Extremes and each named case: singletons at both ends of the range,
    // a run through zero, gap first, gap last, a gap too wide for the field,
    // a run up to the top value, an unsorted set and a multi-gap set.
    task automatic test_directed_edges();
        elem_t q[$];
        set_idling(0, 0);
        q = '{VMIN};                        send_values(q);
        q = '{VMAX};                        send_values(q);
        q = '{-2, -1, 0, 1};                send_values(q);
        q = '{5, 7, 8, 9};                  send_values(q);
        q = '{10, 11, 20};                  send_values(q);
        q = '{VMIN, VMAX};                  send_values(q);
        q = '{VMAX - 1, VMAX};              send_values(q);
        q = '{3, 1, 2};                     send_values(q);
        q = '{0, 1, 5, 6, 9};               send_values(q);
        wait_for_results();
    endtask

    // Set that runs past the store: its tail (closing beat included) is
    // dropped, the search covers the full store and the result comes back
    // flagged.
    task automatic test_full_and_overflow();
        set_idling(32, 32);
        send_run(DEPTH + 3, VMIN_L + 7, 300, 2);
        wait_for_results();
    endtask

    // Long receiver hold-off while the sender keeps offering sets: the result
    // register fills, the next search waits, and the input stalls.
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_left = HOLD_CYCLES;
        for (int s = 0; s < 6; s++)
            send_shaped_set(5);
        wait_for_results();
    endtask

    task automatic test_random_sets();
        int          phase_target;
        int unsigned p;
        int          n;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_idling(0, 0);
                1: set_idling(46, 0);
                2: set_idling(0, 46);
                3: set_idling(32, 32);
            endcase
            phase_target = beats_sent + RANDOM_BEATS / 4;
            while (beats_sent < phase_target) begin
                p = $urandom_range(99);
                if (p < 70)
                    n = $urandom_range(12, 1);
                else if (p < 95)
                    n = $urandom_range(60, 13);
                else
                    n = $urandom_range(200, 61);
                if ($urandom_range(99) < 85)
                    send_shaped_set(n);
                else
                    send_noise_set(n);
            end
            wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.value  = '0;
        in_if.last   = 1'b0;
        out_if.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_full_and_overflow();
        test_backpressure();
        test_random_sets();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (miscompares == 0 && gap_results.size() == 0)
            $display("first_gap_binary_search: match");
        else
            $display("first_gap_binary_search: mismatch");
        $finish;
    end

endmodule
